@@ rtl/assert_macros.svh @@
// Assertion helpers shared by clsr_unit and combined_lcg_shuffle_rng.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/clsr_pkg.sv @@
package clsr_pkg;

	// Generator constants; modulus = mult * quotient + remainder.
	localparam logic [31:0] MUL1 = 32'd40014;
	localparam logic [31:0] QUO1 = 32'd53668;
	localparam logic [31:0] REM1 = 32'd12211;
	localparam logic [31:0] MUL2 = 32'd40692;
	localparam logic [31:0] QUO2 = 32'd52774;
	localparam logic [31:0] REM2 = 32'd3791;
	localparam logic [31:0] MOD1 = 32'(MUL1 * QUO1 + REM1);
	localparam logic [31:0] MOD2 = 32'(MUL2 * QUO2 + REM2);

	localparam logic [30:0] SEED2_RESET = 31'd123456789;

	// floor(x / quotient) = (x * recip) >> 47 for every 31-bit x
	localparam int          SCHRAGE_SHIFT = 47;
	localparam logic [63:0] RECIP1_W = ((64'd1 << SCHRAGE_SHIFT) + 64'(QUO1) - 64'd1) / 64'(QUO1);
	localparam logic [63:0] RECIP2_W = ((64'd1 << SCHRAGE_SHIFT) + 64'(QUO2) - 64'd1) / 64'(QUO2);
	localparam logic [31:0] RECIP1 = RECIP1_W[31:0];
	localparam logic [31:0] RECIP2 = RECIP2_W[31:0];

	localparam int DEF_TABLE_SIZE = 32;

	// input op code
	localparam logic IN_OP_RESEED = 1'b1;

	typedef enum logic [1:0] {
		OP_GEN1,
		OP_GEN2,
		OP_SLOT
	} clsr_op_t;

	typedef struct packed {
		logic     start;
		clsr_op_t op;
	} clsr_cmd_t;

	typedef struct packed {
		logic        done;
		logic [30:0] result;
	} clsr_sts_t;

endpackage

@@ rtl/clsr_unit.sv @@
`include "assert_macros.svh"

// Shared multiply unit: one Schrage step of either generator, or the
// slot index of the previous output, through one registered multiplier.
module clsr_unit #(
	parameter int TABLE_SIZE = clsr_pkg::DEF_TABLE_SIZE
) (
	input  logic                clk,
	input  logic                arst_n,
	input  clsr_pkg::clsr_cmd_t cmd,
	input  logic [30:0]         x,
	output clsr_pkg::clsr_sts_t sts
);
	import clsr_pkg::*;

	localparam logic [63:0] SLOT_DIV   = 64'd1 + (64'(MOD1) - 64'd2) / 64'(TABLE_SIZE);
	localparam int          SLOT_SHIFT = 31 + $clog2(SLOT_DIV);
	localparam logic [63:0] SLOT_RW    = ((64'd1 << SLOT_SHIFT) + SLOT_DIV - 64'd1) / SLOT_DIV;
	localparam logic [31:0] SLOT_RECIP = SLOT_RW[31:0];

	typedef enum logic [1:0] {
		U_IDLE,
		U_K,
		U_AX,
		U_FIN
	} phase_t;

	phase_t      phase_q;
	clsr_op_t    op_q;
	logic [30:0] x_q;
	logic [15:0] k_q;
	logic [46:0] ax_q;
	logic [63:0] prod_q;
	clsr_sts_t   sts_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] recip_sel;
	logic [31:0] mult_sel;
	logic [31:0] mod_sel;
	logic [63:0] slot_full;
	logic [47:0] diff;
	logic [47:0] diff_adj;

	always_comb begin
		unique case (cmd.op)
			OP_GEN1: recip_sel = RECIP1;
			OP_GEN2: recip_sel = RECIP2;
			OP_SLOT: recip_sel = SLOT_RECIP;
			default: recip_sel = '0;
		endcase
		unique case (op_q)
			OP_GEN1: begin
				mult_sel = MUL1;
				mod_sel  = MOD1;
			end
			OP_GEN2: begin
				mult_sel = MUL2;
				mod_sel  = MOD2;
			end
			default: begin
				mult_sel = '0;
				mod_sel  = '0;
			end
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		unique case (phase_q)
			U_IDLE: begin
				mul_a = {1'b0, x};
				mul_b = recip_sel;
			end
			U_K: begin
				mul_a = mult_sel;
				mul_b = {1'b0, x_q};
			end
			U_AX: begin
				mul_a = {16'b0, k_q};
				mul_b = mod_sel;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign slot_full = prod_q >> SLOT_SHIFT;
	// a*x - k*m equals the Schrage form a*(x mod q) - k*r
	assign diff      = {1'b0, ax_q} - {1'b0, prod_q[46:0]};
	assign diff_adj  = diff + {16'b0, mod_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= U_IDLE;
			sts_q.done <= 1'b0;
		end else begin
			prod_q     <= mul_a * mul_b;
			sts_q.done <= 1'b0;
			unique case (phase_q)
				U_IDLE: begin
					if (cmd.start) begin
						op_q    <= cmd.op;
						x_q     <= x;
						phase_q <= U_K;
					end
				end
				U_K: begin
					if (op_q == OP_SLOT) begin
						if (slot_full > 64'(TABLE_SIZE - 1)) begin
							sts_q.result <= 31'(TABLE_SIZE - 1);
						end else begin
							sts_q.result <= slot_full[30:0];
						end
						sts_q.done <= 1'b1;
						phase_q    <= U_IDLE;
					end else begin
						k_q     <= prod_q[SCHRAGE_SHIFT +: 16];
						phase_q <= U_AX;
					end
				end
				U_AX: begin
					ax_q    <= prod_q[46:0];
					phase_q <= U_FIN;
				end
				U_FIN: begin
					sts_q.result <= diff[47] ? diff_adj[30:0] : diff[30:0];
					sts_q.done   <= 1'b1;
					phase_q      <= U_IDLE;
				end
				default: phase_q <= U_IDLE;
			endcase
		end
	end

	assign sts = sts_q;

	`ASSERT_IMPLIES(a_start_idle, clk, arst_n, cmd.start, phase_q == U_IDLE)
	`ASSERT_IMPLIES(a_gen1_range, clk, arst_n, sts_q.done && (op_q == OP_GEN1), 32'(sts_q.result) < MOD1)
	`ASSERT_IMPLIES(a_slot_range, clk, arst_n, sts_q.done && (op_q == OP_SLOT), 32'(sts_q.result) < 32'(TABLE_SIZE))

endmodule

@@ rtl/clsr_ram.sv @@
// Simple dual-port RAM, registered read.
module clsr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = clsr_pkg::DEF_TABLE_SIZE,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/combined_lcg_shuffle_rng.sv @@
// Combined two-generator multiplicative RNG with a shuffle table.
// Input stream (s_*): one transfer per request. s_tuser selects the op:
//   0 draws the next number, 1 reseeds from s_tdata and then draws.
// Output stream (m_*): one transfer per request carrying the deviate,
//   an integer in 1..2147483562 (divide by 2147483563 for a uniform).
// Timing: a draw runs from the accepting edge until m_tvalid rises and
//   s_tready returns, both on the same edge once the output register is
//   free. A reseed first adds TABLE_SIZE + 8 steps of generator one.
//   The pace is set by the single shared multiplier: one Schrage step is
//   a command, three products in sequence and a result; a draw needs a
//   slot divide, two steps, then a table read, combine and register.
// s_tready is high only while no request is in flight.
// The result sits in an output register; a stalled receiver holds it
//   there while the next request is accepted and worked on, and that
//   request waits at its end until the register frees up.
// Reset: generators go to 1 and 123456789, the previous output to 0,
//   and the shuffle table reads as all zeros (per-entry valid bits are
//   cleared, so no sweep is needed and s_tready is high right away).
`include "assert_macros.svh"

module combined_lcg_shuffle_rng #(
	parameter int TABLE_SIZE = clsr_pkg::DEF_TABLE_SIZE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] seed_value, [31] zero pad
	input  logic [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [30:0] value, [31] zero pad
);
	import clsr_pkg::*;

	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CNT_W = $clog2(TABLE_SIZE + 8);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,   // warm-up and table fill steps of generator one
		ST_SLOT,   // slot index from previous output
		ST_G1,
		ST_G2,
		ST_DATA,   // table entry back, combine and refill
		ST_OUT     // wait for the output register
	} state_t;

	state_t          state_q;
	logic [30:0]     g1_q;
	logic [30:0]     g2_q;
	logic [30:0]     last_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] slot_q;
	logic [TABLE_SIZE-1:0] valid_q;
	clsr_cmd_t       ucmd_q;
	logic [30:0]     ux_q;
	logic [30:0]     y_q;
	logic            m_tvalid_q;
	logic [30:0]     m_tdata_q;

	clsr_sts_t       usts;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [30:0]      ram_wdata;
	logic             ram_re;
	logic [30:0]      ram_rdata;

	logic [30:0] seed_eff;
	logic        cnt_fill;
	logic [30:0] tab_val;
	logic [32:0] diff;
	logic [32:0] diff_adj;
	logic [30:0] y_new;

	clsr_unit #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (ucmd_q),
		.x     (ux_q),
		.sts   (usts)
	);

	clsr_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_tdata_q};

	assign seed_eff = (s_tdata[30:0] == '0) ? 31'd1 : s_tdata[30:0];
	assign cnt_fill = 32'(cnt_q) < 32'(TABLE_SIZE);

	// table writes: fill during reseed, refill of the drawn slot
	assign ram_we    = ((state_q == ST_SEED) && usts.done && cnt_fill) || (state_q == ST_DATA);
	assign ram_waddr = (state_q == ST_DATA) ? slot_q : cnt_q[IDX_W-1:0];
	assign ram_wdata = (state_q == ST_DATA) ? g1_q : usts.result;
	assign ram_re    = (state_q == ST_G2) && usts.done;

	// entry minus generator two, wrapped into 1..MOD1-1
	assign tab_val  = valid_q[slot_q] ? ram_rdata : '0;
	assign diff     = {2'b0, tab_val} - {2'b0, g2_q};
	assign diff_adj = diff + 33'(MOD1 - 32'd1);
	assign y_new    = (diff[32] || (diff == '0)) ? diff_adj[30:0] : diff[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			g1_q         <= 31'd1;
			g2_q         <= SEED2_RESET;
			last_q       <= '0;
			valid_q      <= '0;
			ucmd_q.start <= 1'b0;
			ucmd_q.op    <= OP_GEN1;
			m_tvalid_q   <= 1'b0;
		end else begin
			ucmd_q.start <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ucmd_q.start <= 1'b1;
						if (s_tuser[0] == IN_OP_RESEED) begin
							g1_q      <= seed_eff;
							g2_q      <= seed_eff;
							cnt_q     <= CNT_W'(TABLE_SIZE + 7);
							ucmd_q.op <= OP_GEN1;
							ux_q      <= seed_eff;
							state_q   <= ST_SEED;
						end else begin
							ucmd_q.op <= OP_SLOT;
							ux_q      <= last_q;
							state_q   <= ST_SLOT;
						end
					end
				end
				ST_SEED: begin
					if (usts.done) begin
						g1_q         <= usts.result;
						ux_q         <= usts.result;
						ucmd_q.start <= 1'b1;
						if (cnt_fill) begin
							valid_q[cnt_q[IDX_W-1:0]] <= 1'b1;
						end
						if (cnt_q == '0) begin
							last_q    <= usts.result;
							ucmd_q.op <= OP_SLOT;
							state_q   <= ST_SLOT;
						end else begin
							cnt_q     <= cnt_q - 1'b1;
							ucmd_q.op <= OP_GEN1;
						end
					end
				end
				ST_SLOT: begin
					if (usts.done) begin
						slot_q       <= usts.result[IDX_W-1:0];
						ucmd_q.start <= 1'b1;
						ucmd_q.op    <= OP_GEN1;
						ux_q         <= g1_q;
						state_q      <= ST_G1;
					end
				end
				ST_G1: begin
					if (usts.done) begin
						g1_q         <= usts.result;
						ucmd_q.start <= 1'b1;
						ucmd_q.op    <= OP_GEN2;
						ux_q         <= g2_q;
						state_q      <= ST_G2;
					end
				end
				ST_G2: begin
					if (usts.done) begin
						g2_q    <= usts.result;
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					valid_q[slot_q] <= 1'b1;
					last_q          <= y_new;
					y_q             <= y_new;
					state_q         <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= y_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_out_range, clk, arst_n, m_tvalid_q, (m_tdata_q != '0) && (32'(m_tdata_q) < MOD1))
	`ASSERT_NEXT(a_start_quiet, clk, arst_n, ucmd_q.start, !usts.done)
	`ASSERT_IMPLIES(a_slot_bound, clk, arst_n, state_q == ST_DATA, 32'(slot_q) < 32'(TABLE_SIZE))

endmodule

@@ bench/tb_combined_lcg_shuffle_rng.sv @@
module tb_combined_lcg_shuffle_rng;

	import clsr_pkg::*;

	localparam int SLOTS = DEF_TABLE_SIZE;

	// op codes carried on s_tuser
	localparam logic OP_RESEED = IN_OP_RESEED;
	localparam logic OP_DRAW   = ~IN_OP_RESEED;

	// generator arithmetic, kept local to the bench
	localparam longint G1_MOD = 64'sd2147483563;
	localparam longint G1_MUL = 64'sd40014;
	localparam longint G1_QUO = 64'sd53668;
	localparam longint G1_REM = 64'sd12211;
	localparam longint G2_MOD = 64'sd2147483399;
	localparam longint G2_MUL = 64'sd40692;
	localparam longint G2_QUO = 64'sd52774;
	localparam longint G2_REM = 64'sd3791;
	localparam longint SLOT_DIV = 64'sd1 + (G1_MOD - 64'sd2) / SLOTS;

	localparam int RANDOM_REQS = 1730;

	typedef struct {
		logic        op;
		logic [30:0] seed;
		int unsigned gap;          // idle cycles before the transfer is offered
		bit          drain_first;  // hold off until all results are back
	} rng_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [30:0] seed_value, [31] zero pad
	logic [0:0]  s_tuser = '0;   // [0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // [30:0] value, [31] zero pad

	// predictor state
	logic [30:0] gen1;
	logic [30:0] gen2;
	logic [30:0] prev_deviate;
	logic [30:0] shuffle [SLOTS];

	rng_req_t    req_queue [$];
	logic [30:0] deviate_q [$];

	int          n_accepted = 0;
	int          n_checked = 0;
	int          mismatches = 0;
	bit          tx_burst = 1'b0;
	bit          rx_burst = 1'b0;

	// driver scratch
	rng_req_t    cur_req;
	int unsigned gap_left;
	bit          gap_armed = 1'b0;

	// monitor scratch
	int unsigned stall_left;
	logic [30:0] want;

	combined_lcg_shuffle_rng #(
		.TABLE_SIZE(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// x * mul mod modulus without leaving 32 signed bits
	function automatic logic [30:0] schrage_mul(logic [30:0] x, longint mul, longint quo,
			longint rem, longint modulus);
		longint xv;
		longint k;
		longint y;
		xv = longint'(x);
		k = xv / quo;
		y = mul * (xv - k * quo) - k * rem;
		if (y < 0)
			y += modulus;
		return y[30:0];
	endfunction

	function automatic void predictor_reset();
		gen1 = 31'd1;
		gen2 = SEED2_RESET;
		prev_deviate = '0;
		foreach (shuffle[i])
			shuffle[i] = '0;
	endfunction

	// advances the predictor by one request and returns the deviate it yields
	function automatic logic [30:0] next_deviate(logic reseed, logic [30:0] seed);
		longint slot;
		longint y;
		int j;
		if (reseed) begin
			gen1 = (seed == 0) ? 31'd1 : seed;
			gen2 = gen1;
			// 8 warm-up steps, then fill the table top slot first
			for (j = SLOTS + 7; j >= 0; j--) begin
				gen1 = schrage_mul(gen1, G1_MUL, G1_QUO, G1_REM, G1_MOD);
				if (j < SLOTS)
					shuffle[j] = gen1;
			end
			prev_deviate = shuffle[0];
		end
		gen1 = schrage_mul(gen1, G1_MUL, G1_QUO, G1_REM, G1_MOD);
		gen2 = schrage_mul(gen2, G2_MUL, G2_QUO, G2_REM, G2_MOD);
		slot = longint'(prev_deviate) / SLOT_DIV;
		if (slot >= SLOTS)
			slot = SLOTS - 1;
		y = longint'(shuffle[slot]) - longint'(gen2);
		shuffle[slot] = gen1;
		if (y < 1)
			y += G1_MOD - 1;
		prev_deviate = y[30:0];
		return prev_deviate;
	endfunction

	function automatic void add_req(logic op, logic [30:0] seed, bit drain_first);
		rng_req_t r;
		r.op = op;
		r.seed = seed;
		r.gap = tx_burst ? 0 : $urandom_range(0, 17);
		r.drain_first = drain_first;
		req_queue.push_back(r);
	endfunction

	// small seeds, seeds at or above the second modulus, and full-range ones
	function automatic logic [30:0] pick_seed();
		case ($urandom_range(0, 5))
			0: return 31'($urandom_range(0, 15));
			1: return 31'($urandom_range(32'd2147483399, 32'h7FFF_FFFF));
			default: return 31'($urandom());
		endcase
	endfunction

	function automatic void flag_mismatch(string what, logic [31:0] exp_word, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %h, got %h", $time, what, exp_word, got);
	endfunction

	// driver: predicts on every accepted transfer, then offers the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				deviate_q.push_back(next_deviate(s_tuser[0] == OP_RESEED, s_tdata[30:0]));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (!gap_armed && req_queue.size() != 0) begin
					gap_left = req_queue[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_armed && gap_left == 0 &&
						(!req_queue[0].drain_first || n_checked == n_accepted)) begin
					cur_req = req_queue.pop_front();
					gap_armed = 1'b0;
					s_tvalid <= 1'b1;
					s_tuser <= cur_req.op;
					s_tdata <= {1'b0, cur_req.seed};
				end else begin
					if (gap_armed && gap_left != 0)
						gap_left--;
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 1;
		end else begin
			if (m_tvalid && m_tready) begin
				n_checked <= n_checked + 1;
				if (deviate_q.size() == 0) begin
					flag_mismatch("unexpected result", 'x, m_tdata);
				end else begin
					want = deviate_q.pop_front();
					if (m_tdata !== {1'b0, want})
						flag_mismatch("deviate", {1'b0, want}, m_tdata);
				end
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
				stall_left = rx_burst ? 0 : $urandom_range(0, 17);
				m_tready <= (stall_left == 0);
			end else if (!m_tready) begin
				stall_left--;
				if (stall_left == 0)
					m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int i;
		predictor_reset();

		// draws straight out of reset: zero table, slot 0; seed field is ignored
		add_req(OP_DRAW, 31'd0, 1'b0);
		add_req(OP_DRAW, 31'h7FFF_FFFF, 1'b0);
		add_req(OP_DRAW, 31'h2AAA_AAAA, 1'b0);
		// zero seed maps to one
		add_req(OP_RESEED, 31'd0, 1'b0);
		add_req(OP_DRAW, 31'h5555_5555, 1'b0);
		add_req(OP_RESEED, 31'd1, 1'b0);
		add_req(OP_RESEED, 31'h7FFF_FFFF, 1'b0);
		add_req(OP_DRAW, 31'd0, 1'b0);
		// seeds at and above the moduli
		add_req(OP_RESEED, 31'd2147483563, 1'b0);
		add_req(OP_RESEED, 31'd2147483562, 1'b0);
		add_req(OP_RESEED, 31'd2147483399, 1'b0);
		add_req(OP_RESEED, 31'd2147483500, 1'b0);
		add_req(OP_DRAW, 31'd0, 1'b0);
		add_req(OP_RESEED, 31'h2AAA_AAAA, 1'b0);
		add_req(OP_RESEED, 31'h5555_5555, 1'b0);
		add_req(OP_DRAW, 31'd0, 1'b0);
		add_req(OP_DRAW, 31'd0, 1'b1);
		add_req(OP_DRAW, 31'd0, 1'b0);
		add_req(OP_RESEED, 31'd123456789, 1'b0);
		add_req(OP_DRAW, 31'd0, 1'b0);

		// mostly draws, occasional reseeds, idle phases switched on and off
		for (i = 0; i < RANDOM_REQS; i++) begin
			if ($urandom_range(0, 39) == 0)
				tx_burst = !tx_burst;
			if ($urandom_range(0, 24) == 0)
				add_req(OP_RESEED, pick_seed(), $urandom_range(0, 199) == 0);
			else
				add_req(OP_DRAW, 31'($urandom()), $urandom_range(0, 199) == 0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (n_checked != n_accepted)
			@(posedge clk);
		// leave room for anything stray
		repeat (64) @(posedge clk);

		if (mismatches == 0 && deviate_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (deviate_q.size() != 0)
				$display("%0d predicted results never arrived", deviate_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

	// worst case is every request a reseed with full gaps and stalls
	initial begin
		#40_000_000;
		$display("timeout: %0d accepted, %0d checked", n_accepted, n_checked);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/clsr_pkg.sv
rtl/clsr_unit.sv
rtl/clsr_ram.sv
rtl/combined_lcg_shuffle_rng.sv
bench/tb_combined_lcg_shuffle_rng.sv
